// ----- hdl/bata_pkg.sv -----
// Package: shared types and constants for the button autorepeat threshold adjuster.
package bata_pkg;

    localparam int unsigned LEVEL_W = 9;
    localparam int unsigned IV_W    = 6;
    localparam int unsigned HOLD_W  = 8;
    localparam int unsigned BTN_W   = 2;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned CIDX_W  = 2;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [IV_W-1:0]           interval_t;
    typedef logic [HOLD_W-1:0]         hold_t;
    typedef logic [BTN_W-1:0]          button_t;

    localparam button_t BTN_NONE = 2'd0;
    localparam button_t BTN_UP   = 2'd1;
    localparam button_t BTN_DOWN = 2'd2;

    localparam hold_t HOLD_MAX = 8'd255;

    typedef enum logic [CIDX_W-1:0] {
        CFG_UPPER_LIMIT      = 2'd0,
        CFG_LOWER_LIMIT      = 2'd1,
        CFG_INITIAL_INTERVAL = 2'd2,
        CFG_MIN_INTERVAL     = 2'd3
    } cfg_idx_t;

    localparam level_t    UPPER_LIMIT_RST      = 9'sd130;
    localparam level_t    LOWER_LIMIT_RST      = -9'sd30;
    localparam interval_t INITIAL_INTERVAL_RST = 6'd10;
    localparam interval_t MIN_INTERVAL_RST     = 6'd4;
    localparam interval_t REPEAT_INTERVAL_RST  = 6'd10;
    localparam level_t    LEVEL_RST            = 9'sd35;

    typedef struct packed {
        level_t    upper_limit;
        level_t    lower_limit;
        interval_t initial_interval;
        interval_t min_interval;
    } cfg_t;

    typedef struct packed {
        level_t  threshold;
        logic    threshold_changed;
        logic    button_changed;
        button_t previous_button;
    } result_t;

endpackage

// ----- hdl/bata_if.sv -----
// Interfaces: input and result channels with valid/ready handshake.
interface bata_in_if
    import bata_pkg::*;
();
    logic    valid;
    logic    ready;
    button_t button_code;

    modport source (output valid, output button_code, input ready);
    modport sink   (input valid, input button_code, output ready);
endinterface

interface bata_out_if
    import bata_pkg::*;
();
    logic    valid;
    logic    ready;
    level_t  threshold;
    logic    threshold_changed;
    logic    button_changed;
    button_t previous_button;

    modport source (output valid, output threshold, output threshold_changed,
                    output button_changed, output previous_button, input ready);
    modport sink   (input valid, input threshold, input threshold_changed,
                    input button_changed, input previous_button, output ready);
endinterface

// ----- hdl/bata_cfg.sv -----
// Configuration register bank: limits and repeat intervals.
module bata_cfg
    import bata_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_UPPER_LIMIT:      cfg_next.upper_limit      = level_t'(cfg_data);
                CFG_LOWER_LIMIT:      cfg_next.lower_limit      = level_t'(cfg_data);
                CFG_INITIAL_INTERVAL: cfg_next.initial_interval = cfg_data[IV_W-1:0];
                CFG_MIN_INTERVAL:     cfg_next.min_interval     = cfg_data[IV_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_limit      <= UPPER_LIMIT_RST;
            cfg_reg.lower_limit      <= LOWER_LIMIT_RST;
            cfg_reg.initial_interval <= INITIAL_INTERVAL_RST;
            cfg_reg.min_interval     <= MIN_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/bata_core.sv -----
// Step core: input register, hold/interval/level state and per-tick step logic.
module bata_core
    import bata_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  button_t in_button,
    input  logic    can_load,
    output logic    res_load,
    output result_t res
);

    logic      in_vld_reg;
    logic      in_vld_next;
    button_t   btn_reg;
    button_t   last_button_reg;
    button_t   last_button_next;
    hold_t     hold_count_reg;
    hold_t     hold_count_next;
    interval_t interval_reg;
    interval_t interval_next;
    level_t    level_reg;
    level_t    level_next;

    logic      adv;
    logic      changed;
    logic      allowed;
    logic      stepped;
    hold_t     hold_upd;
    interval_t iv_upd;

    assign adv      = in_vld_reg && can_load;
    assign in_ready = !in_vld_reg || adv;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ready)
        begin
            in_vld_next = in_valid;
        end
    end

    always_comb
    begin
        changed = (btn_reg != last_button_reg);
        if (changed)
        begin
            hold_upd = '0;
            iv_upd   = cfg.initial_interval;
        end
        else
        begin
            hold_upd = (hold_count_reg < HOLD_MAX) ? hold_count_reg + 8'd1 : hold_count_reg;
            iv_upd   = interval_reg;
        end

        allowed = (hold_upd == '0) || (hold_upd == {{(HOLD_W-IV_W){1'b0}}, iv_upd});

        priority if (allowed && btn_reg == BTN_UP && level_reg < cfg.upper_limit)
        begin
            stepped    = 1'b1;
            level_next = level_reg + 9'sd1;
        end
        else if (allowed && btn_reg == BTN_DOWN && level_reg > cfg.lower_limit)
        begin
            stepped    = 1'b1;
            level_next = level_reg - 9'sd1;
        end
        else
        begin
            stepped    = 1'b0;
            level_next = level_reg;
        end

        hold_count_next = hold_upd;
        interval_next   = iv_upd;
        if (stepped)
        begin
            hold_count_next = '0;
            if (iv_upd > cfg.min_interval)
            begin
                interval_next = iv_upd - 6'd1;
            end
        end
        last_button_next = btn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            last_button_reg <= BTN_NONE;
            hold_count_reg  <= '0;
            interval_reg    <= REPEAT_INTERVAL_RST;
            level_reg       <= LEVEL_RST;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (adv)
            begin
                last_button_reg <= last_button_next;
                hold_count_reg  <= hold_count_next;
                interval_reg    <= interval_next;
                level_reg       <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            btn_reg <= in_button;
        end
    end

    assign res_load               = adv;
    assign res.threshold          = level_next;
    assign res.threshold_changed  = stepped;
    assign res.button_changed     = changed;
    assign res.previous_button    = last_button_reg;

`ifndef SYNTH
    a_step_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        adv && stepped |=> (level_reg == $past(level_reg) + 9'sd1)
                        || (level_reg == $past(level_reg) - 9'sd1))
        else $error("level moved by other than one on a step");

    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && stepped) |=> $stable(level_reg))
        else $error("level changed without a step");

    a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (changed || stepped) |=> hold_count_reg == '0)
        else $error("hold count not cleared on change or step");

    a_last_button: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> last_button_reg == $past(btn_reg))
        else $error("last button not tracking processed code");
`endif

endmodule

// ----- hdl/bata_out.sv -----
// Result register: holds one result transaction until the sink takes it.
module bata_out
    import bata_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_load,
    input  result_t res,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign can_load = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (can_load)
        begin
            vld_next = res_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

// ----- hdl/button_autorepeat_threshold_adjust.sv -----
// Top level: button autorepeat threshold adjuster.
// The input register holds the button code; the result register holds each result until taken.
// Throughput: one transaction per cycle while the sink is ready; the step logic is combinational.
// Reset (rst_n low, async): threshold 35, interval 10, hold count 0, last button none,
// limits 130 / -30, intervals 10 / 4; both channels empty.
module button_autorepeat_threshold_adjust
    import bata_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    bata_in_if.sink           in_ch,
    bata_out_if.source        out_ch
);

    cfg_t    cfg;
    logic    can_load;
    logic    res_load;
    result_t res;
    result_t out_res;

    bata_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bata_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_button (in_ch.button_code),
        .can_load  (can_load),
        .res_load  (res_load),
        .res       (res)
    );

    bata_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.threshold         = out_res.threshold;
    assign out_ch.threshold_changed = out_res.threshold_changed;
    assign out_ch.button_changed    = out_res.button_changed;
    assign out_ch.previous_button   = out_res.previous_button;

endmodule
